FILE: rtl/sgpm_pkg.sv
// Shared types and constants for the segment glob path matcher.
package sgpm_pkg;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_PATH = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  localparam logic [1:0] MODE_EXACT = 2'd0;
  localparam logic [1:0] MODE_DIR   = 2'd1;
  localparam logic [1:0] MODE_GLOB  = 2'd2;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_LEN  = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] index;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic too_long;
  } out_item_t;

  // Operation carried by the wave that walks the cell chain.
  typedef enum logic [1:0] {
    OP_INIT,
    OP_ADV,
    OP_READ
  } wave_op_t;

  typedef struct packed {
    logic     vld;
    wave_op_t op;
    logic     v;     // column value for the position the wave enters
    logic [1:0] skip;  // positions still inside the current token
    logic     mm;    // literal mismatch seen on this sweep
    logic     fin;   // column bit at the pattern length
  } wave_t;

endpackage

FILE: rtl/sgpm_cell.sv
// One pattern position: pattern byte, active and seen bits, one wave stage.
module sgpm_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 7,
  parameter int CNT_W = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic                 wr_en,
  input  logic [5:0]           wr_idx,
  input  logic [7:0]           wr_data,
  input  logic [LEN_W-1:0]     len,
  input  logic [CNT_W-1:0]     count,
  input  logic [7:0]           path_byte,
  input  sgpm_pkg::wave_t      wave_i,
  output sgpm_pkg::wave_t      wave_o,
  input  logic [7:0]           nb1_byte,
  input  logic [7:0]           nb2_byte,
  input  logic                 nb1_act,
  output logic [7:0]           byte_o,
  output logic                 act_o
);
  import sgpm_pkg::*;

  logic [7:0] byte_r;
  logic       act_r, act_nxt;
  logic       seen_r, seen_nxt;
  wave_t      wave_r, wave_nxt;
  logic       lt0, lt1, lt2, at_len;
  logic       is_slash, is_star, is_dstar, is_w3;

  assign lt0      = IDX < int'(len);
  assign lt1      = (IDX + 1) < int'(len);
  assign lt2      = (IDX + 2) < int'(len);
  assign at_len   = IDX == int'(len);
  assign is_slash = path_byte == CH_SLASH;
  assign is_star  = byte_r == CH_STAR;
  assign is_dstar = is_star && lt1 && (nb1_byte == CH_STAR);
  assign is_w3    = is_dstar && lt2 && (nb2_byte == CH_SLASH);

  always_comb begin
    wave_nxt = wave_i;
    act_nxt  = act_r;
    seen_nxt = seen_r;
    if (wave_i.vld) begin
      case (wave_i.op)
        OP_INIT, OP_ADV: begin
          if (wave_i.op == OP_ADV) begin
            seen_nxt = seen_r | act_r;
            if (lt0 && (IDX == int'(count)) && (byte_r != path_byte)) begin
              wave_nxt.mm = 1'b1;
            end
          end
          if (lt0 && (wave_i.skip == 2'd0)) begin
            // token start: take the incoming value, compute the one after the token
            act_nxt = wave_i.v;
            wave_nxt.skip = is_w3 ? 2'd2 : (is_dstar ? 2'd1 : 2'd0);
            if (wave_i.op == OP_INIT) begin
              wave_nxt.v = is_star & wave_i.v;
            end else if (is_w3) begin
              wave_nxt.v = wave_i.v | ((seen_r | act_r) & is_slash);
            end else if (is_dstar) begin
              wave_nxt.v = wave_i.v | seen_r | act_r;
            end else if (is_star) begin
              wave_nxt.v = wave_i.v | (~is_slash & nb1_act);
            end else if (byte_r == CH_QUEST) begin
              wave_nxt.v = act_r & ~is_slash;
            end else begin
              wave_nxt.v = act_r & (byte_r == path_byte);
            end
          end else if (lt0) begin
            act_nxt = 1'b0;
            wave_nxt.skip = wave_i.skip - 2'd1;
          end else if (at_len) begin
            act_nxt = wave_i.v;
            wave_nxt.fin = wave_i.v;
          end else begin
            act_nxt = 1'b0;
          end
        end
        OP_READ: begin
          if (at_len) begin
            wave_nxt.fin = act_r;
          end
        end
        default: begin
          wave_nxt.vld = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r.vld <= 1'b0;
      act_r      <= 1'b0;
      seen_r     <= 1'b0;
    end else begin
      wave_r <= wave_nxt;
      if (clr) begin
        act_r  <= 1'b0;
        seen_r <= 1'b0;
      end else begin
        act_r  <= act_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (int'(wr_idx) == IDX)) begin
      byte_r <= wr_data;
    end
  end

  assign wave_o = wave_r;
  assign byte_o = byte_r;
  assign act_o  = act_r;

endmodule

FILE: rtl/sgpm_chain.sv
// Row of pattern cells plus the end position past the last pattern byte.
module sgpm_chain #(
  parameter int PATTERN_MAX = 64,
  parameter int LEN_W       = 7,
  parameter int CNT_W       = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             wr_en,
  input  logic [5:0]       wr_idx,
  input  logic [7:0]       wr_data,
  input  logic [LEN_W-1:0] len,
  input  logic [CNT_W-1:0] count,
  input  logic [7:0]       path_byte,
  input  sgpm_pkg::wave_t  wave_in,
  output sgpm_pkg::wave_t  done_wave
);
  import sgpm_pkg::*;

  wave_t      wave_s [PATTERN_MAX+1];
  logic [7:0] byte_s [PATTERN_MAX+2];
  logic       act_s  [PATTERN_MAX+1];
  logic       tail_act_r, tail_act_nxt;
  logic       tail_at_len;

  assign wave_s[0]             = wave_in;
  assign byte_s[PATTERN_MAX]   = 8'h00;
  assign byte_s[PATTERN_MAX+1] = 8'h00;
  assign act_s[PATTERN_MAX]    = tail_act_r;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    sgpm_cell #(
      .IDX   (g),
      .LEN_W (LEN_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clr       (clr),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .len       (len),
      .count     (count),
      .path_byte (path_byte),
      .wave_i    (wave_s[g]),
      .wave_o    (wave_s[g+1]),
      .nb1_byte  (byte_s[g+1]),
      .nb2_byte  (byte_s[g+2]),
      .nb1_act   (act_s[g+1]),
      .byte_o    (byte_s[g]),
      .act_o     (act_s[g])
    );
  end

  // end position: holds the column bit for a full-length pattern
  assign tail_at_len = int'(len) == PATTERN_MAX;

  always_comb begin
    done_wave    = wave_s[PATTERN_MAX];
    tail_act_nxt = tail_act_r;
    if (wave_s[PATTERN_MAX].vld) begin
      case (wave_s[PATTERN_MAX].op)
        OP_INIT, OP_ADV: begin
          tail_act_nxt = tail_at_len & wave_s[PATTERN_MAX].v;
          if (tail_at_len) begin
            done_wave.fin = wave_s[PATTERN_MAX].v;
          end
        end
        OP_READ: begin
          if (tail_at_len) begin
            done_wave.fin = tail_act_r;
          end
        end
        default: begin
          done_wave.vld = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_act_r <= 1'b0;
    end else if (clr) begin
      tail_act_r <= 1'b0;
    end else begin
      tail_act_r <= tail_act_nxt;
    end
  end

endmodule

FILE: rtl/segment_glob_path_matcher.sv
// Top level of the segment glob path matcher: control, registers, result.
//
// A load item writes one pattern byte. A path byte item sends a wave down a
// chain of PATTERN_MAX cells, one pattern position a cycle, to update the
// match column; the block takes no new item until the sweep ends, and for the
// first byte of a path an extra sweep first builds the column for the empty
// path. An end-of-path item runs one read sweep (an init sweep for an empty
// path) and then presents its result in an output register; an overlong path
// reports in the next cycle.
module segment_glob_path_matcher #(
  parameter int PATTERN_MAX = 64,
  parameter int PATH_MAX    = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sgpm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sgpm_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import sgpm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;
  localparam int CNT_W = $clog2(PATH_MAX + 2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_ADV,
    ST_READ
  } state_t;

  state_t           state_r, state_nxt;
  logic             launch_r, launch_nxt;
  logic             end_pend_r, end_pend_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             mm_r, mm_nxt;
  logic             bnd_r, bnd_nxt;
  logic [7:0]       b_r, b_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic [1:0]       mode_r;
  logic [6:0]       len_r;

  logic [CMP_W-1:0] len_ext;
  logic [LEN_W-1:0] eff_len;
  logic             accept, cfg_wr, path_clr, res_match;
  wave_t            wave_in, done_wave;

  assign len_ext = CMP_W'(len_r);
  assign eff_len = (len_ext > CMP_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : LEN_W'(len_ext);

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GLOB;
      len_r  <= 7'd0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_MODE: mode_r <= cfg_pwdata[1:0];
        REG_LEN:  len_r  <= cfg_pwdata[6:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_MODE: cfg_prdata = {30'd0, mode_r};
      REG_LEN:  cfg_prdata = {25'd0, len_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  // wave launched into the first cell in the first cycle of a sweep state
  always_comb begin
    wave_in      = '0;
    wave_in.vld  = launch_r;
    wave_in.v    = state_r == ST_INIT;
    case (state_r)
      ST_INIT: wave_in.op = OP_INIT;
      ST_ADV:  wave_in.op = OP_ADV;
      default: wave_in.op = OP_READ;
    endcase
  end

  sgpm_chain #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W),
    .CNT_W       (CNT_W)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (path_clr),
    .wr_en     (accept && (in_data.command == CMD_LOAD)),
    .wr_idx    (in_data.index),
    .wr_data   (in_data.value),
    .len       (eff_len),
    .count     (count_r),
    .path_byte (b_r),
    .wave_in   (wave_in),
    .done_wave (done_wave)
  );

  always_comb begin
    case (mode_r)
      MODE_EXACT: res_match = !mm_r && (int'(count_r) == int'(eff_len));
      MODE_DIR:   res_match = !mm_r && (int'(count_r) >= int'(eff_len)) &&
                              ((int'(count_r) == int'(eff_len)) || bnd_r);
      MODE_GLOB:  res_match = done_wave.fin;
      default:    res_match = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    end_pend_nxt  = end_pend_r;
    count_nxt     = count_r;
    mm_nxt        = mm_r;
    bnd_nxt       = bnd_r;
    b_nxt         = b_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    path_clr      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_PATH: begin
              if (int'(count_r) >= PATH_MAX) begin
                count_nxt = CNT_W'(PATH_MAX + 1);
              end else begin
                if (int'(count_r) == int'(eff_len)) begin
                  bnd_nxt = in_data.value == CH_SLASH;
                end
                b_nxt        = in_data.value;
                end_pend_nxt = 1'b0;
                launch_nxt   = 1'b1;
                state_nxt    = (count_r == '0) ? ST_INIT : ST_ADV;
              end
            end
            CMD_END: begin
              if (int'(count_r) > PATH_MAX) begin
                out_valid_nxt         = 1'b1;
                out_data_nxt.matched  = 1'b0;
                out_data_nxt.too_long = 1'b1;
                path_clr              = 1'b1;
              end else begin
                end_pend_nxt = 1'b1;
                launch_nxt   = 1'b1;
                state_nxt    = (count_r == '0) ? ST_INIT : ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INIT, ST_READ: begin
        if (done_wave.vld) begin
          if (end_pend_r) begin
            out_valid_nxt         = 1'b1;
            out_data_nxt.matched  = res_match;
            out_data_nxt.too_long = 1'b0;
            path_clr              = 1'b1;
            state_nxt             = ST_IDLE;
          end else begin
            launch_nxt = 1'b1;
            state_nxt  = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        if (done_wave.vld) begin
          mm_nxt    = mm_r | done_wave.mm;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (path_clr) begin
      count_nxt = '0;
      mm_nxt    = 1'b0;
      bnd_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      end_pend_r  <= 1'b0;
      count_r     <= '0;
      mm_r        <= 1'b0;
      bnd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      end_pend_r  <= end_pend_nxt;
      count_r     <= count_nxt;
      mm_r        <= mm_nxt;
      bnd_r       <= bnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    b_r        <= b_nxt;
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= PATH_MAX + 1)
    else $error("path count beyond saturation");

  a_done_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    done_wave.vld |-> (state_r != ST_IDLE))
    else $error("sweep finished while idle");

  a_no_launch_done: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r |-> !done_wave.vld)
    else $error("two waves in the chain");

  a_long_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.matched && out_data_r.too_long))
    else $error("overlong path reported as matched");

  a_long_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.command == CMD_END) && (int'(count_r) > PATH_MAX)) |=> out_valid_r)
    else $error("overlong path item gave no result");

endmodule
